// ===== src/fbsh_pkg.sv =====
// Shared types, status codes and the hex digit function for the font segment converter.
package fbsh_pkg;

	localparam logic [2:0] ST_DATA  = 3'd0;
	localparam logic [2:0] ST_END   = 3'd1;
	localparam logic [2:0] ST_BADMK = 3'd2;
	localparam logic [2:0] ST_BADTY = 3'd3;
	localparam logic [2:0] ST_TRAIL = 3'd4;

	localparam logic [7:0] MARKER_BYTE = 8'h80;
	localparam logic [7:0] TYPE_TEXT   = 8'h01;
	localparam logic [7:0] TYPE_BINARY = 8'h02;
	localparam logic [7:0] TYPE_END    = 8'h03;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_LF     = 8'h0A;

	localparam logic [6:0] LINE_BYTES_RESET = 7'd32;
	localparam logic [6:0] LINE_BYTES_MAX   = 7'd64;
	localparam logic [6:0] LINE_BYTES_MIN   = 7'd1;

	// One queued job for the back end: either a single character, or one binary
	// byte to be written as two hex digits with an optional trailing newline.
	typedef struct packed {
		logic [7:0] data;
		logic [2:0] status;
		logic       hex;
		logic       nl;
	} fbsh_cmd_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		if (v < 4'd10) begin
			return 8'h30 + {4'h0, v};
		end else begin
			return 8'h37 + {4'h0, v};
		end
	endfunction

endpackage

// ===== src/fbsh_front.sv =====
// Front end: parses segment headers and queues a job for each data byte and for each end, trailing or error report.
module fbsh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              cfg_wr_en,
	input  logic [6:0]        cfg_wr_data,
	input  logic              q_full,
	output logic              push,
	output fbsh_pkg::fbsh_cmd_t push_cmd
);

	typedef enum logic [6:0] {
		PH_MARKER = 7'b0000001,
		PH_TYPE   = 7'b0000010,
		PH_LENGTH = 7'b0000100,
		PH_DATA   = 7'b0001000,
		PH_DONE   = 7'b0010000,
		PH_ERRMK  = 7'b0100000,
		PH_ERRTY  = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] remaining_q, remaining_d;
	logic [1:0]  len_idx_q, len_idx_d;
	logic        is_binary_q, is_binary_d;
	logic [6:0]  line_pos_q, line_pos_d;
	logic        warned_q, warned_d;
	logic [6:0]  line_bytes_q;
	logic        accept;
	logic [31:0] rem_dec;
	logic [31:0] rem_len;
	logic [6:0]  line_pos_inc;
	logic        line_end;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Out-of-range line lengths are clamped on write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q <= fbsh_pkg::LINE_BYTES_RESET;
		end else if (cfg_wr_en) begin
			if (cfg_wr_data == 7'd0) begin
				line_bytes_q <= fbsh_pkg::LINE_BYTES_MIN;
			end else if (cfg_wr_data > fbsh_pkg::LINE_BYTES_MAX) begin
				line_bytes_q <= fbsh_pkg::LINE_BYTES_MAX;
			end else begin
				line_bytes_q <= cfg_wr_data;
			end
		end
	end

	assign rem_dec      = remaining_q - 32'd1;
	assign rem_len      = remaining_q | ({24'h0, in_byte} << {len_idx_q, 3'b000});
	assign line_pos_inc = line_pos_q + 7'd1;
	assign line_end     = (line_pos_inc >= line_bytes_q) || (rem_dec == 32'd0);

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		len_idx_d   = len_idx_q;
		is_binary_d = is_binary_q;
		line_pos_d  = line_pos_q;
		warned_d    = warned_q;
		push        = 1'b0;
		push_cmd    = '{data: in_byte, status: fbsh_pkg::ST_DATA, hex: 1'b0, nl: 1'b0};
		if (accept) begin
			unique case (phase_q)
				PH_TYPE: begin
					if (in_byte == fbsh_pkg::TYPE_END) begin
						phase_d         = PH_DONE;
						push            = 1'b1;
						push_cmd.data   = fbsh_pkg::CHAR_LF;
						push_cmd.status = fbsh_pkg::ST_END;
					end else if (in_byte == fbsh_pkg::TYPE_TEXT ||
						in_byte == fbsh_pkg::TYPE_BINARY) begin
						is_binary_d = (in_byte == fbsh_pkg::TYPE_BINARY);
						remaining_d = 32'd0;
						len_idx_d   = 2'd0;
						phase_d     = PH_LENGTH;
					end else begin
						phase_d         = PH_ERRTY;
						push            = 1'b1;
						push_cmd.status = fbsh_pkg::ST_BADTY;
					end
				end
				PH_LENGTH: begin
					remaining_d = rem_len;
					len_idx_d   = len_idx_q + 2'd1;
					if (len_idx_q == 2'd3) begin
						line_pos_d = 7'd0;
						phase_d    = (rem_len == 32'd0) ? PH_MARKER : PH_DATA;
					end
				end
				PH_DATA: begin
					remaining_d = rem_dec;
					push        = 1'b1;
					if (!is_binary_q) begin
						if (rem_dec == 32'd0) begin
							phase_d = PH_MARKER;
						end
						if (in_byte == fbsh_pkg::CHAR_CR) begin
							push_cmd.data = fbsh_pkg::CHAR_LF;
						end
					end else begin
						push_cmd.hex = 1'b1;
						push_cmd.nl  = line_end;
						line_pos_d   = line_end ? 7'd0 : line_pos_inc;
						if (rem_dec == 32'd0) begin
							phase_d = PH_MARKER;
						end
					end
				end
				PH_DONE: begin
					if (!warned_q) begin
						warned_d        = 1'b1;
						push            = 1'b1;
						push_cmd.status = fbsh_pkg::ST_TRAIL;
					end
				end
				PH_ERRMK: begin
					push            = 1'b1;
					push_cmd.data   = 8'h00;
					push_cmd.status = fbsh_pkg::ST_BADMK;
				end
				PH_ERRTY: begin
					push            = 1'b1;
					push_cmd.data   = 8'h00;
					push_cmd.status = fbsh_pkg::ST_BADTY;
				end
				default: begin
					if (in_byte == fbsh_pkg::MARKER_BYTE) begin
						phase_d = PH_TYPE;
					end else begin
						phase_d         = PH_ERRMK;
						push            = 1'b1;
						push_cmd.status = fbsh_pkg::ST_BADMK;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MARKER;
			remaining_q <= 32'd0;
			len_idx_q   <= 2'd0;
			is_binary_q <= 1'b0;
			line_pos_q  <= 7'd0;
			warned_q    <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			len_idx_q   <= len_idx_d;
			is_binary_q <= is_binary_d;
			line_pos_q  <= line_pos_d;
			warned_q    <= warned_d;
		end
	end

endmodule

// ===== src/fbsh_queue.sv =====
// Small register queue of jobs between the front end and the back end.
module fbsh_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  fbsh_pkg::fbsh_cmd_t push_cmd,
	output logic                full,
	input  logic                pop,
	output logic                not_empty,
	output fbsh_pkg::fbsh_cmd_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	fbsh_pkg::fbsh_cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/fbsh_back.sv =====
// Back end: expands each queued job into one to three output characters.
module fbsh_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  fbsh_pkg::fbsh_cmd_t q_head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_char,
	output logic [2:0]          status,
	output logic                last
);

	fbsh_pkg::fbsh_cmd_t cmd_q;
	logic                valid_q;
	logic [1:0]          step_q;
	logic                final_step;

	// A hex job ends after the low digit, or after the newline when one is due.
	assign final_step = !cmd_q.hex || (step_q == 2'd1 && !cmd_q.nl) || (step_q == 2'd2);
	assign pop        = q_not_empty && (!valid_q || (out_ready && final_step));

	assign out_valid = valid_q;
	assign status    = cmd_q.status;
	assign last      = final_step;

	always_comb begin
		if (!cmd_q.hex) begin
			out_char = cmd_q.data;
		end else begin
			unique case (step_q)
				2'd0:    out_char = fbsh_pkg::hex_digit(cmd_q.data[7:4]);
				2'd1:    out_char = fbsh_pkg::hex_digit(cmd_q.data[3:0]);
				default: out_char = fbsh_pkg::CHAR_LF;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 2'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			step_q  <= 2'd0;
		end else if (valid_q && out_ready) begin
			if (final_step) begin
				valid_q <= 1'b0;
			end else begin
				step_q <= step_q + 2'd1;
			end
		end
	end

endmodule

// ===== src/font_binary_segment_to_hex_text.sv =====
// Throughput: one output character per cycle while out_ready is high. A binary
// byte gives two or three characters, a text byte one and a header byte none, so
// the single character-wide output port sets the pace. Input bytes are accepted
// while the job queue is not full. Reset (arst_n low) clears the parser state and
// the job queue and sets the line length to 32 bytes.
module font_binary_segment_to_hex_text #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic [2:0] status,
	output logic       last
);

	fbsh_pkg::fbsh_cmd_t push_cmd, q_head;
	logic                push, q_full, q_not_empty, pop;

	fbsh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	fbsh_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.not_empty(q_not_empty),
		.head     (q_head)
	);

	fbsh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_not_empty(q_not_empty),
		.q_head     (q_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.status     (status),
		.last       (last)
	);

endmodule

// ===== tb/fbsh_checker.sv =====
// Predicts the hex text stream of the font segment converter and compares every output item.
`timescale 1ns / 100ps
module fbsh_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_char,
	input  logic [2:0] status,
	input  logic       last,
	output int         mismatches,
	output int         pending
);

	typedef enum logic [2:0] {
		SEG_MARKER,
		SEG_TYPE,
		SEG_LENGTH,
		SEG_DATA,
		SEG_DONE,
		SEG_ERR_MARKER,
		SEG_ERR_TYPE
	} seg_state_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [2:0] st;
		logic       lst;
	} text_char_t;

	text_char_t  chars_due[$];
	seg_state_t  seg_state   = SEG_MARKER;
	logic [31:0] seg_left    = '0;
	logic [1:0]  len_idx     = '0;
	logic        seg_binary  = 1'b0;
	logic [6:0]  line_pos    = '0;
	logic        trail_given = 1'b0;
	logic [6:0]  line_len    = fbsh_pkg::LINE_BYTES_RESET;
	int          errs        = 0;

	function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + 8'(nib);
		end
		return 8'h41 + 8'(nib) - 8'd10;
	endfunction

	task automatic push_char(input logic [7:0] ch, input logic [2:0] st, input logic lst);
		text_char_t c;
		c.ch  = ch;
		c.st  = st;
		c.lst = lst;
		chars_due.push_back(c);
	endtask

	task automatic predict_byte(input logic [7:0] b);
		case (seg_state)
			SEG_TYPE: begin
				if (b == fbsh_pkg::TYPE_END) begin
					seg_state = SEG_DONE;
					push_char(fbsh_pkg::CHAR_LF, fbsh_pkg::ST_END, 1'b1);
				end else if (b == fbsh_pkg::TYPE_TEXT || b == fbsh_pkg::TYPE_BINARY) begin
					seg_binary = (b == fbsh_pkg::TYPE_BINARY);
					seg_left   = '0;
					len_idx    = '0;
					seg_state  = SEG_LENGTH;
				end else begin
					seg_state = SEG_ERR_TYPE;
					push_char(b, fbsh_pkg::ST_BADTY, 1'b1);
				end
			end
			SEG_LENGTH: begin
				seg_left = seg_left | ({24'b0, b} << (8 * len_idx));
				len_idx  = len_idx + 2'd1;
				if (len_idx == 2'd0) begin
					line_pos  = '0;
					seg_state = (seg_left == 32'd0) ? SEG_MARKER : SEG_DATA;
				end
			end
			SEG_DATA: begin
				seg_left = seg_left - 32'd1;
				if (!seg_binary) begin
					if (seg_left == 32'd0) begin
						seg_state = SEG_MARKER;
					end
					push_char((b == fbsh_pkg::CHAR_CR) ? fbsh_pkg::CHAR_LF : b,
						fbsh_pkg::ST_DATA, 1'b1);
				end else begin
					push_char(ascii_hex(b[7:4]), fbsh_pkg::ST_DATA, 1'b0);
					line_pos = line_pos + 7'd1;
					// The line also closes when a shorter length was set mid-line.
					if (line_pos >= line_len || seg_left == 32'd0) begin
						line_pos = '0;
						if (seg_left == 32'd0) begin
							seg_state = SEG_MARKER;
						end
						push_char(ascii_hex(b[3:0]), fbsh_pkg::ST_DATA, 1'b0);
						push_char(fbsh_pkg::CHAR_LF, fbsh_pkg::ST_DATA, 1'b1);
					end else begin
						push_char(ascii_hex(b[3:0]), fbsh_pkg::ST_DATA, 1'b1);
					end
				end
			end
			SEG_DONE: begin
				if (!trail_given) begin
					trail_given = 1'b1;
					push_char(b, fbsh_pkg::ST_TRAIL, 1'b1);
				end
			end
			SEG_ERR_MARKER: push_char(8'h00, fbsh_pkg::ST_BADMK, 1'b1);
			SEG_ERR_TYPE:   push_char(8'h00, fbsh_pkg::ST_BADTY, 1'b1);
			default: begin
				if (b == fbsh_pkg::MARKER_BYTE) begin
					seg_state = SEG_TYPE;
				end else begin
					seg_state = SEG_ERR_MARKER;
					push_char(b, fbsh_pkg::ST_BADMK, 1'b1);
				end
			end
		endcase
	endtask

	task automatic check_char();
		text_char_t got;
		text_char_t want;
		got.ch  = out_char;
		got.st  = status;
		got.lst = last;
		if (chars_due.size() == 0) begin
			errs++;
			if (errs <= 10) begin
				$display("%0t: unexpected item char %h status %0d last %0b",
					$realtime, got.ch, got.st, got.lst);
			end
		end else begin
			want = chars_due.pop_front();
			if (got !== want) begin
				errs++;
				if (errs <= 10) begin
					$display("%0t: got char %h status %0d last %0b, %s %h status %0d last %0b",
						$realtime, got.ch, got.st, got.lst, "wanted char",
						want.ch, want.st, want.lst);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_state   = SEG_MARKER;
			seg_left    = '0;
			len_idx     = '0;
			seg_binary  = 1'b0;
			line_pos    = '0;
			trail_given = 1'b0;
			line_len    = fbsh_pkg::LINE_BYTES_RESET;
			chars_due.delete();
			pending    <= 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_wr_data == 7'd0) begin
					line_len = fbsh_pkg::LINE_BYTES_MIN;
				end else if (cfg_wr_data > fbsh_pkg::LINE_BYTES_MAX) begin
					line_len = fbsh_pkg::LINE_BYTES_MAX;
				end else begin
					line_len = cfg_wr_data;
				end
			end
			if (in_valid && in_ready) begin
				predict_byte(in_byte);
			end
			if (out_valid && out_ready) begin
				check_char();
			end
			pending    <= chars_due.size();
			mismatches <= errs;
		end
	end

endmodule

// ===== tb/tb_font_binary_segment_to_hex_text.sv =====
// Drives segmented font streams and line length settings into the converter and gives the verdict.
`timescale 1ns / 100ps
module tb_font_binary_segment_to_hex_text;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte     = 8'h00;
	logic       cfg_wr_en   = 1'b0;
	logic [6:0] cfg_wr_data = 7'd0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] out_char;
	logic [2:0] status;
	logic       last;
	int         mismatches;
	int         pending;

	logic [7:0] font_stream[$];
	logic [6:0] width_plan[7] = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65, 7'd3, 7'd32};

	int unsigned stall_mode = 0;
	int unsigned stall_left = 0;
	logic [2:0]  stall_tick = '0;

	always #5 clk = ~clk;

	font_binary_segment_to_hex_text dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.status     (status),
		.last       (last)
	);

	fbsh_checker char_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.status     (status),
		.last       (last),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// The receiver switches between always ready, coin flips, heavy stalls and a fixed beat.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 3'd1;
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (stall_tick != 3'd5 && stall_tick != 3'd6);
		endcase
	end

	task automatic push_bytes(input logic [7:0] b[]);
		foreach (b[i]) begin
			font_stream.push_back(b[i]);
		end
	endtask

	task automatic add_segment();
		int unsigned len;
		int unsigned pick;
		logic        bin;
		bin  = ($urandom_range(0, 99) < 55);
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			len = $urandom_range(0, 12);
		end else if (pick < 95) begin
			len = $urandom_range(13, 40);
		end else begin
			len = $urandom_range(41, 70);
		end
		push_bytes('{fbsh_pkg::MARKER_BYTE,
			bin ? fbsh_pkg::TYPE_BINARY : fbsh_pkg::TYPE_TEXT,
			len[7:0], len[15:8], len[23:16], len[31:24]});
		repeat (len) begin
			if (!bin && $urandom_range(0, 4) == 0) begin
				font_stream.push_back(fbsh_pkg::CHAR_CR);
			end else begin
				font_stream.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// The stream can end only once per run, so one way of ending it is drawn here.
	task automatic add_tail();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: begin
				push_bytes('{fbsh_pkg::MARKER_BYTE, fbsh_pkg::TYPE_END});
			end
			1: begin
				do begin
					b = 8'($urandom_range(0, 255));
				end while (b == fbsh_pkg::MARKER_BYTE);
				font_stream.push_back(b);
			end
			2: begin
				do begin
					b = 8'($urandom_range(0, 255));
				end while (b == fbsh_pkg::TYPE_TEXT || b == fbsh_pkg::TYPE_BINARY ||
					b == fbsh_pkg::TYPE_END);
				push_bytes('{fbsh_pkg::MARKER_BYTE, b});
			end
			default: begin
				// A binary segment with a length far beyond the run.
				push_bytes('{fbsh_pkg::MARKER_BYTE, fbsh_pkg::TYPE_BINARY,
					8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)) | 8'h80});
			end
		endcase
		repeat (12) begin
			font_stream.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic feed_items(input int unsigned n);
		int unsigned burst_left;
		int unsigned gap;
		burst_left = $urandom_range(1, 24);
		for (int unsigned k = 0; k < n && font_stream.size() != 0; k++) begin
			in_valid <= 1'b1;
			in_byte  <= font_stream.pop_front();
			@(posedge clk);
			while (!in_ready) begin
				@(posedge clk);
			end
			burst_left--;
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
		end
		in_valid <= 1'b0;
	endtask

	// Header and length bytes give no item, so after pending drains an extra wait covers any still in flight.
	task automatic settle();
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic set_line_len(input logic [6:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("font_binary_segment_to_hex_text: mismatch");
		$finish;
	end

	initial begin
		int unsigned phase_no;
		int unsigned drain_cycles;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_line_len(7'd2);

		// Text with CR and byte extremes, an empty segment, then a short binary run.
		push_bytes('{fbsh_pkg::MARKER_BYTE, fbsh_pkg::TYPE_TEXT, 8'd3, 8'd0, 8'd0, 8'd0,
			fbsh_pkg::CHAR_CR, 8'h00, 8'hFF});
		push_bytes('{fbsh_pkg::MARKER_BYTE, fbsh_pkg::TYPE_BINARY, 8'd0, 8'd0, 8'd0, 8'd0});
		push_bytes('{fbsh_pkg::MARKER_BYTE, fbsh_pkg::TYPE_BINARY, 8'd5, 8'd0, 8'd0, 8'd0,
			8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h0F});
		feed_items(font_stream.size());

		while (font_stream.size() < 340) begin
			add_segment();
		end
		add_tail();

		// Phases cut the stream anywhere, so a new line length often lands mid-line.
		phase_no = 0;
		while (font_stream.size() != 0) begin
			settle();
			if (phase_no < 7) begin
				set_line_len(width_plan[phase_no]);
			end else if ($urandom_range(0, 3) == 0) begin
				set_line_len(7'($urandom_range(0, 127)));
			end else begin
				set_line_len(7'($urandom_range(1, 64)));
			end
			phase_no++;
			feed_items($urandom_range(15, 70));
		end

		@(posedge clk);
		drain_cycles = 0;
		while (pending != 0 && drain_cycles < 20000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("font_binary_segment_to_hex_text: match");
		end else begin
			$display("font_binary_segment_to_hex_text: mismatch");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/fbsh_pkg.sv
src/fbsh_front.sv
src/fbsh_queue.sv
src/fbsh_back.sv
src/font_binary_segment_to_hex_text.sv
tb/fbsh_checker.sv
tb/tb_font_binary_segment_to_hex_text.sv
